// File: hw/rtl/u2mr_pkg.sv
// Shared types, codes and mapping tables for the UTF-16 to MacRoman name encoder.
// No dependencies; the front end, queue, back end and top level refer to this package by scoped names.

package u2mr_pkg;

	localparam logic [7:0] QMARK = 8'h3F;

	// status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FALLBACK = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	// unit classes decided by the front end
	localparam logic [1:0] KIND_ASCII   = 2'd0;
	localparam logic [1:0] KIND_ACCENT  = 2'd1;
	localparam logic [1:0] KIND_CEDILLA = 2'd2;
	localparam logic [1:0] KIND_OTHER   = 2'd3;

	localparam logic [15:0] ASCII_END    = 16'h0080;
	localparam logic [15:0] ACCENT_FIRST = 16'h0300;
	localparam logic [15:0] ACCENT_LAST  = 16'h030A;
	localparam logic [15:0] CEDILLA_CP   = 16'h0327;

	// base letter window 'A' .. 'y'
	localparam logic [6:0] LETTER_FIRST = 7'h41;
	localparam logic [6:0] LETTER_END   = 7'h7A;
	localparam logic [6:0] CHAR_C_UP    = 7'h43;
	localparam logic [6:0] CHAR_C_LO    = 7'h63;
	localparam logic [7:0] MAC_CCED_UP  = 8'h82;
	localparam logic [7:0] MAC_CCED_LO  = 8'h8D;

	localparam int NUM_BASES   = 14;
	localparam int NUM_ACCENTS = 11;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [6:0] BASE_LETTERS [NUM_BASES] = '{
		7'h41, 7'h61, 7'h45, 7'h65, 7'h49, 7'h69, 7'h4E,
		7'h6E, 7'h4F, 7'h6F, 7'h55, 7'h75, 7'h59, 7'h79
	};

	localparam logic [7:0] COMPOSED [NUM_BASES][NUM_ACCENTS] = '{
		'{8'hCB, 8'hE7, 8'hE5, 8'hCC, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h80, 8'h3F, 8'h81},
		'{8'h88, 8'h87, 8'h89, 8'h8B, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h8A, 8'h3F, 8'h8C},
		'{8'hE9, 8'h83, 8'hE6, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hE8, 8'h3F, 8'h3F},
		'{8'h8F, 8'h8E, 8'h90, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h91, 8'h3F, 8'h3F},
		'{8'hED, 8'hEA, 8'hEB, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hEC, 8'h3F, 8'h3F},
		'{8'h93, 8'h92, 8'h94, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h95, 8'h3F, 8'h3F},
		'{8'h3F, 8'h3F, 8'h3F, 8'h84, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F},
		'{8'h3F, 8'h3F, 8'h3F, 8'h96, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F},
		'{8'hF1, 8'hEE, 8'hEF, 8'hCD, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h85, 8'h3F, 8'h3F},
		'{8'h98, 8'h97, 8'h99, 8'h9B, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h9A, 8'h3F, 8'h3F},
		'{8'hF4, 8'hF2, 8'hF3, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h86, 8'h3F, 8'h3F},
		'{8'h9D, 8'h9C, 8'h9E, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h9F, 8'h3F, 8'h3F},
		'{8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hD9, 8'h3F, 8'h3F},
		'{8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hD8, 8'h3F, 8'h3F}
	};

	// classified unit as it sits in the queue
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] val;   // ASCII byte, accent column or mapped byte
		logic       last;
	} u2mr_cls_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} u2mr_fifo_stat_t;

	// composed byte for a base letter and accent column; '?' when none
	function automatic logic [7:0] compose(input logic [6:0] base, input logic [3:0] col);
		logic [7:0] res;
		res = QMARK;
		if (col < 4'(NUM_ACCENTS)) begin
			for (int r = 0; r < NUM_BASES; r++) begin
				if (BASE_LETTERS[r] == base) begin
					res = COMPOSED[r][col];
				end
			end
		end
		return res;
	endfunction

	// MacRoman byte for a non-combining unit at or above 0x80
	function automatic logic [7:0] map_single(input logic [15:0] c);
		logic [7:0] res;
		unique case (c)
			16'h00A0: res = 8'hCA; 16'h00A1: res = 8'hC1;
			16'h00A2: res = 8'hA2; 16'h00A3: res = 8'hA3;
			16'h00A4: res = 8'hDB; 16'h00A5: res = 8'hB4;
			16'h00A7: res = 8'hA4; 16'h00A8: res = 8'hAC;
			16'h00A9: res = 8'hA9; 16'h00AA: res = 8'hBB;
			16'h00AB: res = 8'hC7; 16'h00AC: res = 8'hC2;
			16'h00AE: res = 8'hA8; 16'h00AF: res = 8'hF8;
			16'h00B0: res = 8'hA1; 16'h00B1: res = 8'hB1;
			16'h00B4: res = 8'hAB; 16'h00B5: res = 8'hB5;
			16'h00B6: res = 8'hA6; 16'h00B7: res = 8'hE1;
			16'h00B8: res = 8'hFC; 16'h00BA: res = 8'hBC;
			16'h00BB: res = 8'hC8; 16'h00BF: res = 8'hC0;
			16'h00C6: res = 8'hAE; 16'h00D8: res = 8'hAF;
			16'h00DF: res = 8'hA7; 16'h00E6: res = 8'hBE;
			16'h00F7: res = 8'hD6; 16'h00F8: res = 8'hBF;
			16'h0131: res = 8'hF5; 16'h0152: res = 8'hCE;
			16'h0153: res = 8'hCF; 16'h0192: res = 8'hC4;
			16'h02C6: res = 8'hF6; 16'h02C7: res = 8'hFF;
			16'h02D8: res = 8'hF9; 16'h02D9: res = 8'hFA;
			16'h02DA: res = 8'hFB; 16'h02DB: res = 8'hFE;
			16'h02DC: res = 8'hF7; 16'h02DD: res = 8'hFD;
			16'h03A9: res = 8'hBD; 16'h03C0: res = 8'hB9;
			16'h2013: res = 8'hD0; 16'h2014: res = 8'hD1;
			16'h2018: res = 8'hD4; 16'h2019: res = 8'hD5;
			16'h201A: res = 8'hE2; 16'h201C: res = 8'hD2;
			16'h201D: res = 8'hD3; 16'h201E: res = 8'hE3;
			16'h2020: res = 8'hA0; 16'h2021: res = 8'hE0;
			16'h2022: res = 8'hA5; 16'h2026: res = 8'hC9;
			16'h2030: res = 8'hE4; 16'h2039: res = 8'hDC;
			16'h203A: res = 8'hDD; 16'h2044: res = 8'hDA;
			16'h20AC: res = 8'hDB; 16'h2122: res = 8'hAA;
			16'h2202: res = 8'hB6; 16'h2206: res = 8'hC6;
			16'h220F: res = 8'hB8; 16'h2211: res = 8'hB7;
			16'h221A: res = 8'hC3; 16'h221E: res = 8'hB0;
			16'h222B: res = 8'hBA; 16'h2248: res = 8'hC5;
			16'h2260: res = 8'hAD; 16'h2264: res = 8'hB2;
			16'h2265: res = 8'hB3; 16'h25CA: res = 8'hD7;
			16'hF8FF: res = 8'hF0; 16'hFB01: res = 8'hDE;
			16'hFB02: res = 8'hDF;
			default:  res = QMARK;
		endcase
		return res;
	endfunction

endpackage

// File: hw/rtl/u2mr_channels.sv
// Valid/ready channel interfaces for the name encoder: UTF-16 units in, byte writes out.
// No dependencies.

interface u2mr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last;

	modport source(output valid, code_unit, last, input ready);
	modport sink(input valid, code_unit, last, output ready);
endinterface

interface u2mr_out_if #(
	parameter int CNT_W = 5
);
	logic             valid;
	logic             ready;
	logic             write_enable;
	logic [CNT_W-1:0] position;
	logic [7:0]       out_byte;
	logic             done_res;
	logic [CNT_W-1:0] name_length;
	logic [1:0]       status;

	modport source(output valid, write_enable, position, out_byte, done_res, name_length,
		status, input ready);
	modport sink(input valid, write_enable, position, out_byte, done_res, name_length,
		status, output ready);
endinterface

// File: hw/rtl/u2mr_front.sv
// Front end: accepts UTF-16 units and classifies them into queue entries.
// Depends on u2mr_pkg and u2mr_in_if.

module u2mr_front (
	u2mr_in_if.sink                 in_ch,
	input  u2mr_pkg::u2mr_fifo_stat_t fifo_stat,
	output logic                    push,
	output u2mr_pkg::u2mr_cls_t     push_data
);

	logic [15:0] c;

	assign c            = in_ch.code_unit;
	assign in_ch.ready  = !fifo_stat.full;
	assign push         = in_ch.valid && !fifo_stat.full;

	always_comb begin
		push_data.last = in_ch.last;
		if (c < u2mr_pkg::ASCII_END) begin
			push_data.kind = u2mr_pkg::KIND_ASCII;
			push_data.val  = {1'b0, c[6:0]};
		end else if (c >= u2mr_pkg::ACCENT_FIRST && c <= u2mr_pkg::ACCENT_LAST) begin
			push_data.kind = u2mr_pkg::KIND_ACCENT;
			push_data.val  = {4'b0, c[3:0]};
		end else if (c == u2mr_pkg::CEDILLA_CP) begin
			push_data.kind = u2mr_pkg::KIND_CEDILLA;
			push_data.val  = u2mr_pkg::QMARK;
		end else begin
			push_data.kind = u2mr_pkg::KIND_OTHER;
			push_data.val  = u2mr_pkg::map_single(c);
		end
	end

endmodule

// File: hw/rtl/u2mr_fifo.sv
// Short queue of classified units between front and back end.
// Depends on u2mr_pkg.

module u2mr_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  u2mr_pkg::u2mr_cls_t       push_data,
	input  logic                      pop,
	output u2mr_pkg::u2mr_cls_t       pop_data,
	output u2mr_pkg::u2mr_fifo_stat_t stat
);

	u2mr_pkg::u2mr_cls_t                 mem_q [u2mr_pkg::FIFO_DEPTH];
	logic [u2mr_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [u2mr_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [u2mr_pkg::FIFO_CNT_W-1:0]     cnt_q;

	assign stat.not_empty = (cnt_q != '0);
	assign stat.full      = (cnt_q == u2mr_pkg::FIFO_CNT_W'(u2mr_pkg::FIFO_DEPTH));
	assign pop_data       = mem_q[rd_ptr_q];

	function automatic logic [u2mr_pkg::FIFO_PTR_W-1:0] ptr_inc(
		input logic [u2mr_pkg::FIFO_PTR_W-1:0] p
	);
		logic [u2mr_pkg::FIFO_PTR_W-1:0] res;
		if (p == u2mr_pkg::FIFO_PTR_W'(u2mr_pkg::FIFO_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = p + 1'b1;
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/u2mr_back.sv
// Back end: per-name state (base letter, byte count, flags) and the output register.
// Depends on u2mr_pkg and u2mr_out_if.

module u2mr_back #(
	parameter int MAX_NAME_BYTES = 31,
	parameter int CNT_W          = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  u2mr_pkg::u2mr_cls_t q_data,
	output logic                pop,
	u2mr_out_if.source          out_ch
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NAME_BYTES);

	logic [6:0]       prev_ascii_q;
	logic [CNT_W-1:0] byte_count_q;
	logic             fallback_q;
	logic             overflow_q;
	logic             out_valid_q;

	logic             write_enable_q;
	logic [CNT_W-1:0] position_q;
	logic [7:0]       out_byte_q;
	logic             done_q;
	logic [CNT_W-1:0] name_length_q;
	logic [1:0]       status_q;

	logic             merge;
	logic [7:0]       mapped;
	logic [6:0]       base_next;
	logic             fb_hit;
	logic [CNT_W-1:0] wpos;
	logic             base_ok;

	logic             we_n;
	logic [CNT_W-1:0] pos_n;
	logic [7:0]       byte_n;
	logic [CNT_W-1:0] cnt_n;
	logic [6:0]       prev_n;
	logic             fb_n;
	logic             ovf_n;
	logic [1:0]       status_n;

	assign pop = q_valid && (!out_valid_q || out_ch.ready);

	assign base_ok = prev_ascii_q >= u2mr_pkg::LETTER_FIRST &&
		prev_ascii_q < u2mr_pkg::LETTER_END && byte_count_q != '0;

	// resolve the unit against the base letter
	always_comb begin
		merge     = 1'b0;
		mapped    = q_data.val;
		base_next = '0;
		unique case (q_data.kind)
			u2mr_pkg::KIND_ASCII: begin
				base_next = q_data.val[6:0];
			end
			u2mr_pkg::KIND_ACCENT: begin
				if (base_ok) begin
					mapped = u2mr_pkg::compose(prev_ascii_q, q_data.val[3:0]);
					merge  = 1'b1;
				end else begin
					mapped = u2mr_pkg::QMARK;
				end
			end
			u2mr_pkg::KIND_CEDILLA: begin
				if ((prev_ascii_q == u2mr_pkg::CHAR_C_UP ||
						prev_ascii_q == u2mr_pkg::CHAR_C_LO) && byte_count_q != '0) begin
					mapped = (prev_ascii_q == u2mr_pkg::CHAR_C_UP) ?
						u2mr_pkg::MAC_CCED_UP : u2mr_pkg::MAC_CCED_LO;
					merge  = 1'b1;
				end else begin
					mapped = u2mr_pkg::QMARK;
				end
			end
			default: begin
				mapped = q_data.val;
			end
		endcase
		fb_hit = (q_data.kind != u2mr_pkg::KIND_ASCII) && (mapped == u2mr_pkg::QMARK);
		wpos   = merge ? byte_count_q - 1'b1 : byte_count_q;
	end

	// commit or drop
	always_comb begin
		we_n   = 1'b0;
		pos_n  = '0;
		byte_n = '0;
		cnt_n  = byte_count_q;
		prev_n = prev_ascii_q;
		fb_n   = fallback_q;
		ovf_n  = 1'b1;
		if (!overflow_q) begin
			fb_n = fallback_q | fb_hit;
			if (wpos < MAX_CNT) begin
				ovf_n  = 1'b0;
				we_n   = 1'b1;
				pos_n  = wpos;
				byte_n = mapped;
				cnt_n  = wpos + 1'b1;
				prev_n = base_next;
			end
		end
		priority if (ovf_n) begin
			status_n = u2mr_pkg::STATUS_TOO_LONG;
		end else if (fb_n) begin
			status_n = u2mr_pkg::STATUS_FALLBACK;
		end else begin
			status_n = u2mr_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			write_enable_q <= we_n;
			position_q     <= pos_n;
			out_byte_q     <= byte_n;
			done_q         <= q_data.last;
			name_length_q  <= cnt_n;
			status_q       <= status_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_ascii_q <= '0;
			byte_count_q <= '0;
			fallback_q   <= 1'b0;
			overflow_q   <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (q_data.last) begin
					prev_ascii_q <= '0;
					byte_count_q <= '0;
					fallback_q   <= 1'b0;
					overflow_q   <= 1'b0;
				end else begin
					prev_ascii_q <= prev_n;
					byte_count_q <= cnt_n;
					fallback_q   <= fb_n;
					overflow_q   <= ovf_n;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.write_enable = write_enable_q;
	assign out_ch.position     = position_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.done_res     = done_q;
	assign out_ch.name_length  = name_length_q;
	assign out_ch.status       = status_q;

endmodule

// File: hw/rtl/utf16_to_macroman_name_encoder.sv
// Top level of the UTF-16 to MacRoman name encoder: front end, queue, back end.
// Depends on u2mr_pkg, u2mr_channels, u2mr_front, u2mr_fifo and u2mr_back.
//
//   channel  | dir | payload                                              | transfer
//   ---------+-----+------------------------------------------------------+-----------------
//   in_ch    | in  | code_unit[15:0], last                                | valid && ready
//   out_ch   | out | write_enable, position, out_byte, done_res,          | valid && ready
//            |     | name_length, status[1:0]                             |
//
// One unit per cycle sustained unless out_ch stalls; each unit gives exactly one result,
// held in the queue and then the output register. The rate is set by the back-end state
// update (base letter and byte count), which resolves one unit per cycle unless stalled.
// Reset clears the per-name state, empties the queue and drops the output valid; no
// clearing pass. A stalled output holds its register; the two-entry queue absorbs the
// mismatch and input ready drops only when the queue is full.

module utf16_to_macroman_name_encoder #(
	parameter int MAX_NAME_BYTES = 31,
	parameter int CNT_W          = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	u2mr_in_if.sink     in_ch,
	u2mr_out_if.source  out_ch
);

	// queue handshake between the two halves
	logic                      push;
	u2mr_pkg::u2mr_cls_t       push_data;
	logic                      pop;
	u2mr_pkg::u2mr_cls_t       pop_data;
	u2mr_pkg::u2mr_fifo_stat_t fifo_stat;

	// classify each unit: ASCII, combining accent, cedilla, or a mapped single
	u2mr_front u_front (
		.in_ch     (in_ch),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_data (push_data)
	);

	// decouple acceptance from output stalls
	u2mr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (fifo_stat)
	);

	// compose against the previous base letter, advance the byte count, raise status
	u2mr_back #(
		.MAX_NAME_BYTES (MAX_NAME_BYTES),
		.CNT_W          (CNT_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (fifo_stat.not_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.out_ch  (out_ch)
	);

	// a written byte always lies inside the name reported with it
	a_pos_in_name: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.write_enable |-> out_ch.position < out_ch.name_length)
		else $error("written position outside reported name length");

	// a dropped unit only happens once the name has overflowed
	a_drop_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.write_enable |-> out_ch.status == u2mr_pkg::STATUS_TOO_LONG)
		else $error("unit dropped without too-long status");

	// a transferred unit is held in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> fifo_stat.not_empty)
		else $error("accepted unit missing from queue");

endmodule
